/* rtl/sap_pkg.sv */
// Package for the servo angle to pulse width mapper.
// Holds payload and limit structs, register indexes, constants and the clamp function.
// No dependencies.
package sap_pkg;

  localparam int unsigned ANGW = 28;
  localparam int unsigned PULW = 13;
  localparam int unsigned QW   = 13;
  localparam int unsigned DENW = 20;
  localparam int unsigned REMW = 33;

  localparam logic signed [ANGW-1:0] ANGLE_LO      = -28'sd23592960;
  localparam logic signed [ANGW-1:0] ANGLE_HI      = 28'sd67108864;
  localparam logic signed [ANGW-1:0] RST_MIN_ANGLE = -28'sd5898240;
  localparam logic signed [ANGW-1:0] RST_MAX_ANGLE = 28'sd5898240;
  localparam logic [PULW-1:0]        PULSE_HI      = 13'd6000;
  localparam logic [PULW-1:0]        RST_MIN_PULSE = 13'd500;
  localparam logic [PULW-1:0]        RST_MAX_PULSE = 13'd2500;

  typedef enum logic [2:0] {
    REG_ANGLE_OFFSET = 3'd0,
    REG_MIN_ANGLE    = 3'd1,
    REG_MAX_ANGLE    = 3'd2,
    REG_MIN_PULSE    = 3'd3,
    REG_MAX_PULSE    = 3'd4,
    REG_LIMITS_FIXED = 3'd5
  } sap_reg_t;

  typedef struct packed {
    logic signed [31:0] commanded_angle;
    logic [7:0]         intensity;
  } sap_in_t;

  typedef struct packed {
    logic [PULW-1:0]        pulse_width_us;
    logic                   drive_enabled;
    logic signed [ANGW-1:0] angle_readback;
  } sap_out_t;

  typedef struct packed {
    logic signed [ANGW-1:0] amin;
    logic signed [ANGW-1:0] amax;
    logic signed [ANGW-1:0] off;
    logic [PULW-1:0]        pmin;
    logic [PULW-1:0]        dp_mag;
    logic                   dp_neg;
    logic [DENW-1:0]        den_mag;
    logic                   den_neg;
    logic                   den_zero;
  } sap_lim_t;

  typedef struct packed {
    logic [REMW-1:0]        rem;
    logic [QW-1:0]          quo;
    logic                   neg;
    logic signed [ANGW-1:0] rb;
    logic                   on;
  } sap_div_t;

  function automatic logic signed [32:0] clip_s33(input logic signed [32:0] lo,
                                                  input logic signed [32:0] v,
                                                  input logic signed [32:0] hi);
    logic signed [32:0] res;
    if (v < lo) begin
      res = lo;
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

/* rtl/sap_cfg.sv */
// Configuration registers and derived effective limits.
// Two register levels: clamped limits and offset, then span, pulse delta and divisor.
// Depends on sap_pkg.
module sap_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_wdata,
  output sap_pkg::sap_lim_t lim
);
  import sap_pkg::*;

  logic signed [31:0]     offset_r;
  logic signed [31:0]     min_ang_r;
  logic signed [31:0]     max_ang_r;
  logic [15:0]            min_pul_r;
  logic [15:0]            max_pul_r;
  logic                   fixed_r;

  logic signed [ANGW-1:0] amin_nxt, amax_nxt, off_nxt;
  logic [PULW-1:0]        pmin_nxt, pmax_nxt;
  logic signed [ANGW-1:0] amin_r, amax_r, off_r;
  logic [PULW-1:0]        pmin_r, pmax_r;

  logic signed [PULW:0]   dp_c;
  logic signed [ANGW-1:0] span_c;
  logic signed [DENW-1:0] den_c;
  logic [PULW-1:0]        dp_mag_nxt, dp_mag_r;
  logic                   dp_neg_nxt, dp_neg_r;
  logic [DENW-1:0]        den_mag_nxt, den_mag_r;
  logic                   den_neg_nxt, den_neg_r;
  logic                   den_zero_nxt, den_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= '0;
      min_ang_r <= 32'(RST_MIN_ANGLE);
      max_ang_r <= 32'(RST_MAX_ANGLE);
      min_pul_r <= 16'(RST_MIN_PULSE);
      max_pul_r <= 16'(RST_MAX_PULSE);
      fixed_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (sap_reg_t'(cfg_index))
        REG_ANGLE_OFFSET: offset_r  <= cfg_wdata;
        REG_MIN_ANGLE:    min_ang_r <= cfg_wdata;
        REG_MAX_ANGLE:    max_ang_r <= cfg_wdata;
        REG_MIN_PULSE:    min_pul_r <= cfg_wdata[15:0];
        REG_MAX_PULSE:    max_pul_r <= cfg_wdata[15:0];
        REG_LIMITS_FIXED: fixed_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fixed_r) begin
      amin_nxt = RST_MIN_ANGLE;
      amax_nxt = RST_MAX_ANGLE;
      pmin_nxt = RST_MIN_PULSE;
      pmax_nxt = RST_MAX_PULSE;
    end else begin
      amin_nxt = ANGW'(clip_s33(33'(ANGLE_LO), 33'(min_ang_r), 33'(ANGLE_HI)));
      amax_nxt = ANGW'(clip_s33(33'(ANGLE_LO), 33'(max_ang_r), 33'(ANGLE_HI)));
      pmin_nxt = (min_pul_r > 16'(PULSE_HI)) ? PULSE_HI : min_pul_r[PULW-1:0];
      pmax_nxt = (max_pul_r > 16'(PULSE_HI)) ? PULSE_HI : max_pul_r[PULW-1:0];
    end
    off_nxt = ANGW'(clip_s33(33'(amin_nxt), 33'(offset_r), 33'(amax_nxt)));
  end

  always_comb begin
    dp_c         = $signed({1'b0, pmax_r}) - $signed({1'b0, pmin_r});
    dp_neg_nxt   = dp_c[PULW];
    dp_mag_nxt   = dp_neg_nxt ? PULW'(-dp_c) : dp_c[PULW-1:0];
    span_c       = amax_r - amin_r;
    den_c        = span_c[ANGW-1:8];
    den_neg_nxt  = den_c[DENW-1];
    den_mag_nxt  = den_neg_nxt ? DENW'(-den_c) : den_c;
    den_zero_nxt = (den_c == '0);
  end

  always_ff @(posedge clk) begin
    amin_r     <= amin_nxt;
    amax_r     <= amax_nxt;
    off_r      <= off_nxt;
    pmin_r     <= pmin_nxt;
    pmax_r     <= pmax_nxt;
    dp_mag_r   <= dp_mag_nxt;
    dp_neg_r   <= dp_neg_nxt;
    den_mag_r  <= den_mag_nxt;
    den_neg_r  <= den_neg_nxt;
    den_zero_r <= den_zero_nxt;
  end

  always_comb begin
    lim.amin     = amin_r;
    lim.amax     = amax_r;
    lim.off      = off_r;
    lim.pmin     = pmin_r;
    lim.dp_mag   = dp_mag_r;
    lim.dp_neg   = dp_neg_r;
    lim.den_mag  = den_mag_r;
    lim.den_neg  = den_neg_r;
    lim.den_zero = den_zero_r;
  end

endmodule

/* rtl/sap_front.sv */
// Front pipeline: input register, offset add, angle clamp, scaling and multiply.
// Five stages, each with its own valid bit; hands magnitude and sign to the divider.
// Depends on sap_pkg.
module sap_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sap_pkg::sap_in_t  in_data,
  input  sap_pkg::sap_lim_t lim,
  output logic              out_valid,
  input  logic              out_ready,
  output sap_pkg::sap_div_t out_data
);
  import sap_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic signed [31:0]     p1_cmd_r;
  logic                   p1_on_r;
  logic signed [32:0]     sum_nxt, p2_sum_r;
  logic                   p2_on_r;
  logic signed [ANGW-1:0] ang_nxt, p3_ang_r;
  logic                   p3_on_r;
  logic signed [ANGW-1:0] diff_c;
  logic signed [DENW-1:0] a_nxt, p4_a_r;
  logic signed [ANGW-1:0] rb_nxt, p4_rb_r;
  logic                   p4_on_r;
  logic [DENW-1:0]        a_mag_c;
  logic [REMW-1:0]        prod_nxt, p5_prod_r;
  logic                   neg_nxt, p5_neg_r;
  logic signed [ANGW-1:0] p5_rb_r;
  logic                   p5_on_r;

  always_comb begin
    rdy5     = !v5_r || out_ready;
    rdy4     = !v4_r || rdy5;
    rdy3     = !v3_r || rdy4;
    rdy2     = !v2_r || rdy3;
    rdy1     = !v1_r || rdy2;
    in_ready = rdy1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_comb begin
    sum_nxt  = 33'(p1_cmd_r) + 33'($signed(lim.off));
    ang_nxt  = ANGW'(clip_s33(33'($signed(lim.amin)), p2_sum_r, 33'($signed(lim.amax))));
    diff_c   = p3_ang_r - $signed(lim.amin);
    a_nxt    = diff_c[ANGW-1:8];
    rb_nxt   = p3_ang_r - $signed(lim.off);
    a_mag_c  = p4_a_r[DENW-1] ? DENW'(-p4_a_r) : p4_a_r;
    prod_nxt = {{(REMW-DENW){1'b0}}, a_mag_c} * {{(REMW-PULW){1'b0}}, lim.dp_mag};
    neg_nxt  = p4_a_r[DENW-1] ^ lim.dp_neg ^ lim.den_neg;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      p1_cmd_r <= in_data.commanded_angle;
      p1_on_r  <= (in_data.intensity != 8'd0);
    end
    if (rdy2) begin
      p2_sum_r <= sum_nxt;
      p2_on_r  <= p1_on_r;
    end
    if (rdy3) begin
      p3_ang_r <= ang_nxt;
      p3_on_r  <= p2_on_r;
    end
    if (rdy4) begin
      p4_a_r  <= a_nxt;
      p4_rb_r <= rb_nxt;
      p4_on_r <= p3_on_r;
    end
    if (rdy5) begin
      p5_prod_r <= prod_nxt;
      p5_neg_r  <= neg_nxt;
      p5_rb_r   <= p4_rb_r;
      p5_on_r   <= p4_on_r;
    end
  end

  always_comb begin
    out_valid    = v5_r;
    out_data.rem = p5_prod_r;
    out_data.quo = '0;
    out_data.neg = p5_neg_r;
    out_data.rb  = p5_rb_r;
    out_data.on  = p5_on_r;
  end

endmodule

/* rtl/sap_div_stage.sv */
// One stage of the restoring divider: resolves a single quotient bit.
// Holds its own valid bit and item; the divisor magnitude comes from the limit block.
// Depends on sap_pkg.
module sap_div_stage #(
  parameter int unsigned SHIFT = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  sap_pkg::sap_div_t         in_data,
  input  logic [sap_pkg::DENW-1:0]  den_mag,
  output logic                      out_valid,
  input  logic                      out_ready,
  output sap_pkg::sap_div_t         out_data
);
  import sap_pkg::*;

  logic            v_r;
  sap_div_t        d_r;
  sap_div_t        d_nxt;
  logic [REMW-1:0] trial_c;

  always_comb begin
    in_ready = !v_r || out_ready;
    trial_c  = {{(REMW-DENW){1'b0}}, den_mag} << SHIFT;
    d_nxt    = in_data;
    if (in_data.rem >= trial_c) begin
      d_nxt.rem = in_data.rem - trial_c;
      d_nxt.quo = in_data.quo | (QW'(1) << SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

/* rtl/servo_angle_to_pulse_top.sv */
// Top level of the servo angle to pulse width mapper.
// Instantiates sap_cfg, sap_front and a chain of sap_div_stage; holds the output register.
// Depends on sap_pkg.
//
// Takes one item per clock while the output side does not stall and returns one result
// per item, in order, through five front stages (input register, offset add, angle
// clamp, scaling, 20x13 multiply), thirteen divider stages that each resolve one
// quotient bit, and the output register. The thirteen divider stages form a restoring
// divider. Each stage holds its item until the next one frees, so bubbles close up
// and a stall drops or repeats nothing. After a configuration write the derived
// limits settle through the two register levels of sap_cfg, in step with the
// stages that read them.
module servo_angle_to_pulse_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  sap_pkg::sap_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sap_pkg::sap_out_t out_data
);
  import sap_pkg::*;

  sap_lim_t lim;

  logic     div_v   [0:QW];
  logic     div_rdy [0:QW];
  sap_div_t div_d   [0:QW];

  logic                   out_valid_r;
  sap_out_t               out_data_r;
  sap_out_t               out_nxt;
  logic signed [PULW:0]   q_c;

  sap_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .lim       (lim)
  );

  sap_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .lim       (lim),
    .out_valid (div_v[0]),
    .out_ready (div_rdy[0]),
    .out_data  (div_d[0])
  );

  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_div
      sap_div_stage #(
        .SHIFT (QW - 1 - k)
      ) u_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_v[k]),
        .in_ready  (div_rdy[k]),
        .in_data   (div_d[k]),
        .den_mag   (lim.den_mag),
        .out_valid (div_v[k+1]),
        .out_ready (div_rdy[k+1]),
        .out_data  (div_d[k+1])
      );
    end
  endgenerate

  assign div_rdy[QW] = !out_valid_r || out_ready;

  always_comb begin
    q_c = div_d[QW].neg ? -$signed({1'b0, div_d[QW].quo}) : $signed({1'b0, div_d[QW].quo});
    out_nxt.pulse_width_us = lim.den_zero ? lim.pmin
                                          : PULW'(q_c + $signed({1'b0, lim.pmin}));
    out_nxt.drive_enabled  = div_d[QW].on;
    out_nxt.angle_readback = div_d[QW].rb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_rdy[QW]) begin
      out_valid_r <= div_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (div_rdy[QW]) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
